// ----- rtl/core/skq_pkg.sv -----
package skq_pkg;

   localparam int KEY_BITS  = 16;
   localparam int DATA_BITS = 8;
   localparam int OCC_BITS  = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } skq_op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } skq_status_type;

   typedef struct packed {
      skq_op_type                  op;
      logic signed [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0]        item_data;
   } skq_req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] out_data;
      skq_status_type       status;
      logic [OCC_BITS-1:0]  occupancy;
   } skq_rsp_type;

   // shift commands broadcast along the chain
   typedef struct packed {
      logic ins;
      logic rem;
   } skq_shift_type;

endpackage

// ----- rtl/core/skq_cell.sv -----
module skq_cell (
   input  logic                                clock,
   input  skq_pkg::skq_shift_type              shift,
   input  logic signed [skq_pkg::KEY_BITS-1:0] cmp_key,
   input  logic [skq_pkg::DATA_BITS-1:0]       new_data,
   input  logic                                valid,
   input  logic                                left_ge,
   input  logic                                left_match,
   input  logic signed [skq_pkg::KEY_BITS-1:0] left_key,
   input  logic [skq_pkg::DATA_BITS-1:0]       left_data,
   input  logic signed [skq_pkg::KEY_BITS-1:0] right_key,
   input  logic [skq_pkg::DATA_BITS-1:0]       right_data,
   output logic                                ge,
   output logic                                match,
   output logic signed [skq_pkg::KEY_BITS-1:0] key,
   output logic [skq_pkg::DATA_BITS-1:0]       data,
   output logic [skq_pkg::DATA_BITS-1:0]       sel_data
);
   import skq_pkg::*;

   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [DATA_BITS-1:0]       data_ff, data_in;

   // empty cells count as "greater or equal": insert point is the first ge cell
   assign ge       = !valid || (key_ff >= cmp_key);
   assign match    = valid && (key_ff == cmp_key);
   assign key      = key_ff;
   assign data     = data_ff;
   assign sel_data = (match && !left_match) ? data_ff : '0;

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      if (shift.ins && ge) begin
         if (left_ge) begin
            key_in  = left_key;
            data_in = left_data;
         end else begin
            key_in  = cmp_key;
            data_in = new_data;
         end
      end else if (shift.rem && valid && ge) begin
         key_in  = right_key;
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

endmodule

// ----- rtl/core/sorted_key_queue_core.sv -----
// A request is held in the request register and moves on into the result register
// once the result side can take it; the result item is presented from there.
// Throughput: one item per cycle while the result side keeps up; each item passes
// through the request register and one compare-and-shift step in the cell chain.
// Reset clears the entry count, request and result valid flags; cell contents are
// left as they are and only entries below the count are ever looked at.
module sorted_key_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  skq_pkg::skq_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output skq_pkg::skq_rsp_type rsp_payload
);
   import skq_pkg::*;

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   // request stage
   logic        busy_ff, busy_in;
   skq_req_type req_ff, req_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   skq_rsp_type rsp_ff, rsp_in;

   // number of entries held; cells at index >= count are empty
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic accept;
   logic exec;
   logic full;
   logic empty;
   logic found;
   logic [DATA_BITS-1:0] found_data;
   skq_shift_type shift;

   // per-cell wiring of the chain
   logic [CAPACITY-1:0]        cell_valid;
   logic [CAPACITY-1:0]        cell_ge;
   logic [CAPACITY-1:0]        cell_match;
   logic signed [KEY_BITS-1:0] cell_key  [CAPACITY];
   logic [DATA_BITS-1:0]       cell_data [CAPACITY];
   logic [DATA_BITS-1:0]       cell_sel  [CAPACITY];

   // the request stage empties when its item moves on into the result register,
   // so a new item can be taken at that same edge
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || exec;
   assign accept    = req_valid && req_ready;

   assign full  = (count_ff == CNT_BITS'(CAPACITY));
   assign empty = (count_ff == '0);
   assign found = |cell_match;

   // only one cell, the first hit in key order, drives non-zero data
   always_comb begin
      found_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found_data = found_data | cell_sel[i];
      end
   end

   always_comb begin
      shift.ins = exec && (req_ff.op == OP_INSERT) && !full;
      shift.rem = exec && (req_ff.op == OP_REMOVE) && found;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic                       l_ge;
         logic                       l_match;
         logic signed [KEY_BITS-1:0] l_key;
         logic [DATA_BITS-1:0]       l_data;
         logic signed [KEY_BITS-1:0] r_key;
         logic [DATA_BITS-1:0]       r_data;

         assign cell_valid[g] = (CNT_BITS'(g) < count_ff);

         if (g == 0) begin : g_head
            assign l_ge    = 1'b0;
            assign l_match = 1'b0;
            assign l_key   = '0;
            assign l_data  = '0;
         end else begin : g_body
            assign l_ge    = cell_ge[g-1];
            assign l_match = cell_match[g-1];
            assign l_key   = cell_key[g-1];
            assign l_data  = cell_data[g-1];
         end

         // the tail cell pulls in an empty slot on removal
         if (g == CAPACITY - 1) begin : g_tail
            assign r_key  = '0;
            assign r_data = '0;
         end else begin : g_mid
            assign r_key  = cell_key[g+1];
            assign r_data = cell_data[g+1];
         end

         skq_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .cmp_key    (req_ff.key),
            .new_data   (req_ff.item_data),
            .valid      (cell_valid[g]),
            .left_ge    (l_ge),
            .left_match (l_match),
            .left_key   (l_key),
            .left_data  (l_data),
            .right_key  (r_key),
            .right_data (r_data),
            .ge         (cell_ge[g]),
            .match      (cell_match[g]),
            .key        (cell_key[g]),
            .data       (cell_data[g]),
            .sel_data   (cell_sel[g])
         );
      end
   endgenerate

   // control and result
   always_comb begin
      busy_in      = busy_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      count_in     = count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (exec) begin
         busy_in         = 1'b0;
         rsp_valid_in    = 1'b1;
         rsp_in.out_data = '0;
         if (req_ff.op == OP_INSERT) begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_OK;
               count_in      = count_ff + CNT_BITS'(1);
            end
         end else begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (found) begin
               rsp_in.status   = ST_OK;
               rsp_in.out_data = found_data;
               count_in        = count_ff - CNT_BITS'(1);
            end else begin
               rsp_in.status = ST_MISSING;
            end
         end
         rsp_in.occupancy = OCC_BITS'(count_in);
      end

      if (accept) begin
         busy_in = 1'b1;
         req_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
